@@ rtl/rpnc_pkg.sv @@
// Shared constants, types and state encoding for the RPN stack calculator.
// Used by the stack RAM, the divider and the top level; depends on nothing.

package rpnc_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Q16.16 data format.
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    // Command codes carried on the input tuser.
    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_PEEK = 3'd5;

    // Status codes carried on the output tuser.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_FEW     = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PEEK,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_WB,
        S_RESP
    } state_t;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
    } div_req_t;

    // Answer from the divider.
    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [DATA_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ rtl/rpnc_stack_ram.sv @@
// Stack storage: one write port and one read port with registered read data.
// Depends on rpnc_pkg for depth and data width.

module rpnc_stack_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [rpnc_pkg::ADDR_W-1:0] waddr,
    input  logic [rpnc_pkg::DATA_W-1:0] wdata,
    input  logic [rpnc_pkg::ADDR_W-1:0] raddr,
    output logic [rpnc_pkg::DATA_W-1:0] rdata
);

    logic [rpnc_pkg::DATA_W-1:0] mem [rpnc_pkg::STACK_DEPTH];
    logic [rpnc_pkg::DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rpnc_div.sv @@
// Restoring divider for Q16.16 magnitudes: (num << 16) / den, one quotient bit a cycle.
// Depends on rpnc_pkg for the request and response structs.

module rpnc_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  rpnc_pkg::div_req_t req,
    output rpnc_pkg::div_rsp_t rsp
);

    localparam int DW = rpnc_pkg::DATA_W;
    localparam int FW = rpnc_pkg::FRAC_W;
    localparam int STEP_W = $clog2(DW);

    logic              busy_reg;
    logic              done_reg;
    logic              ovf_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     quot_reg;
    logic [DW-1:0]     den_reg;

    logic [DW:0]       shifted;
    logic [DW:0]       trial;
    logic              fits;
    logic              ovf_now;

    // The quotient overflows 32 bits when the dividend's upper part already reaches the divisor.
    assign ovf_now = {{(DW - (DW - FW)){1'b0}}, req.num_mag[DW-1:FW]} >= req.den_mag;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign shifted = {rem_reg, quot_reg[DW-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = !trial[DW];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= !ovf_now;
                done_reg <= ovf_now;
                step_reg <= STEP_W'(DW - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ovf_reg  <= ovf_now;
            den_reg  <= req.den_mag;
            rem_reg  <= {{FW{1'b0}}, req.num_mag[DW-1:FW]};
            quot_reg <= {req.num_mag[FW-1:0], {(DW - FW){1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial[DW-1:0] : shifted[DW-1:0];
            quot_reg <= {quot_reg[DW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ rtl/rpn_stack_calculator.sv @@
// Top level of the RPN stack calculator: command sequencer, Q16.16 arithmetic and stream ports.
// Depends on rpnc_pkg, rpnc_stack_ram and rpnc_div.

// One request goes in on the slave stream (command on tuser, operand on tdata) and one
// result comes out on the master stream for each. Requests are handled one at a time; a
// new request is taken as soon as the previous one has been placed in the output register,
// even if that result has not yet been taken. After it is accepted in S_IDLE, a push goes
// straight to S_RESP, a peek passes S_PEEK, add and subtract pass S_RD_B, S_RD_A, S_EXEC and
// S_WB, multiply also passes S_MUL, and divide waits in S_DIV while the divider produces one
// quotient bit per cycle over 32 steps. A divide whose quotient overflows saturates without
// running the steps. Stack full, too few operands, peek when empty and an invalid command go
// straight to S_RESP; divide by zero is found in S_EXEC, only after both operands have been
// read. A result that cannot yet enter the output register holds the sequencer in S_RESP
// until it can. The stack lives in a single-port-read RAM with registered read data; the
// two operands are read in consecutive cycles.

module rpn_stack_calculator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] value_out, [39:32] depth_out
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    localparam int DW    = rpnc_pkg::DATA_W;
    localparam int FW    = rpnc_pkg::FRAC_W;
    localparam int AW    = rpnc_pkg::ADDR_W;
    localparam int CW    = rpnc_pkg::CNT_W;

    // Magnitude of a two's complement value; the most negative value maps to 2^31.
    function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] x);
        begin
            mag_of = x[DW-1] ? (~x + 1'b1) : x;
        end
    endfunction

    // Apply a sign to a magnitude and saturate to the signed 32-bit range.
    function automatic logic [DW-1:0] sat_mag(input logic [DW+FW-1:0] mag, input logic neg);
        logic [DW+FW-1:0] min_mag;
        logic [DW+FW-1:0] max_mag;
        logic [DW-1:0]    low;
        begin
            min_mag = (DW + FW)'(1) << (DW - 1);
            max_mag = min_mag - 1'b1;
            low     = mag[DW-1:0];
            if (neg)
            begin
                sat_mag = (mag >= min_mag) ? {1'b1, {(DW - 1){1'b0}}} : (~low + 1'b1);
            end
            else
            begin
                sat_mag = (mag > max_mag) ? {1'b0, {(DW - 1){1'b1}}} : low;
            end
        end
    endfunction

    // Saturate a 33-bit sum to the signed 32-bit range.
    function automatic logic [DW-1:0] sat_sum(input logic [DW:0] s);
        begin
            if (s[DW] != s[DW-1])
            begin
                sat_sum = s[DW] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
            end
            else
            begin
                sat_sum = s[DW-1:0];
            end
        end
    endfunction

    rpnc_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic [DW-1:0]      a_reg, a_next;
    logic [DW-1:0]      b_reg, b_next;
    logic [2*DW-1:0]    prod_reg, prod_next;
    logic [2:0]         res_status_reg, res_status_next;
    logic [DW-1:0]      res_value_reg, res_value_next;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_status_reg, out_status_next;
    logic [DW-1:0]      out_value_reg, out_value_next;
    logic [7:0]         out_depth_reg, out_depth_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [DW-1:0]      ram_rdata;

    rpnc_pkg::div_req_t div_req;
    rpnc_pkg::div_rsp_t div_rsp;

    logic               in_fire;
    logic               out_free;
    logic               full;
    logic               neg;
    logic [DW:0]        sum_ext;
    logic [31:0]        cnt_wide;

    rpnc_stack_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpnc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_axis_tready = (state_reg == rpnc_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign full          = (cnt_reg == CW'(rpnc_pkg::STACK_DEPTH));
    assign neg           = a_reg[DW-1] ^ b_reg[DW-1];
    assign cnt_wide      = 32'(cnt_reg);

    // Add or subtract on sign-extended operands.
    assign sum_ext = (cmd_reg == rpnc_pkg::CMD_SUB)
                   ? ({a_reg[DW-1], a_reg} - {b_reg[DW-1], b_reg})
                   : ({a_reg[DW-1], a_reg} + {b_reg[DW-1], b_reg});

    // The read address follows the sequencer: top entry first, then the one below it.
    assign ram_raddr = (state_reg == rpnc_pkg::S_RD_B) ? AW'(cnt_reg - CW'(2))
                                                       : AW'(cnt_reg - CW'(1));

    // Sequencer: next state, memory write, divider start and result formation.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_depth_next  = out_depth_reg;
        ram_we          = 1'b0;
        ram_waddr       = AW'(cnt_reg);
        ram_wdata       = s_axis_tdata;
        div_req.start   = 1'b0;
        div_req.num_mag = mag_of(a_reg);
        div_req.den_mag = mag_of(b_reg);

        unique case (state_reg)
            rpnc_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next        = s_axis_tuser;
                    res_value_next  = '0;
                    res_status_next = rpnc_pkg::ST_OK;
                    state_next      = rpnc_pkg::S_RESP;
                    unique case (s_axis_tuser)
                        rpnc_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                res_status_next = rpnc_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                cnt_next       = cnt_reg + 1'b1;
                                res_value_next = s_axis_tdata;
                            end
                        end
                        rpnc_pkg::CMD_ADD, rpnc_pkg::CMD_SUB,
                        rpnc_pkg::CMD_MUL, rpnc_pkg::CMD_DIV:
                        begin
                            if (cnt_reg < CW'(2))
                            begin
                                res_status_next = rpnc_pkg::ST_FEW;
                            end
                            else
                            begin
                                state_next = rpnc_pkg::S_RD_B;
                            end
                        end
                        rpnc_pkg::CMD_PEEK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = rpnc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = rpnc_pkg::S_PEEK;
                            end
                        end
                        default:
                        begin
                            res_status_next = rpnc_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            rpnc_pkg::S_PEEK:
            begin
                res_value_next = ram_rdata;
                state_next     = rpnc_pkg::S_RESP;
            end
            rpnc_pkg::S_RD_B:
            begin
                b_next     = ram_rdata;
                state_next = rpnc_pkg::S_RD_A;
            end
            rpnc_pkg::S_RD_A:
            begin
                a_next     = ram_rdata;
                state_next = rpnc_pkg::S_EXEC;
            end
            rpnc_pkg::S_EXEC:
            begin
                unique case (cmd_reg)
                    rpnc_pkg::CMD_MUL:
                    begin
                        prod_next  = mag_of(a_reg) * mag_of(b_reg);
                        state_next = rpnc_pkg::S_MUL;
                    end
                    rpnc_pkg::CMD_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            res_status_next = rpnc_pkg::ST_DIVZERO;
                            state_next      = rpnc_pkg::S_RESP;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = rpnc_pkg::S_DIV;
                        end
                    end
                    default:
                    begin
                        res_value_next = sat_sum(sum_ext);
                        state_next     = rpnc_pkg::S_WB;
                    end
                endcase
            end
            rpnc_pkg::S_MUL:
            begin
                res_value_next = sat_mag(prod_reg[2*DW-1:FW], neg);
                state_next     = rpnc_pkg::S_WB;
            end
            rpnc_pkg::S_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_value_next = div_rsp.ovf
                                   ? sat_mag({{FW{1'b1}}, {DW{1'b0}}}, neg)
                                   : sat_mag({{FW{1'b0}}, div_rsp.quot}, neg);
                    state_next     = rpnc_pkg::S_WB;
                end
            end
            rpnc_pkg::S_WB:
            begin
                // The result replaces the lower operand and the stack shrinks by one.
                ram_we     = 1'b1;
                ram_waddr  = AW'(cnt_reg - CW'(2));
                ram_wdata  = res_value_reg;
                cnt_next   = cnt_reg - 1'b1;
                state_next = rpnc_pkg::S_RESP;
            end
            rpnc_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_depth_next  = cnt_wide[7:0];
                    state_next      = rpnc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpnc_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpnc_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_depth_reg  <= out_depth_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_depth_reg, out_value_reg};

    // The entry count never passes the stack depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(rpnc_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    // Any error result carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != rpnc_pkg::ST_OK)) |-> (m_axis_tdata[31:0] == '0))
        else $error("error result with nonzero value");

    // The write-back of an arithmetic result pops exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpnc_pkg::S_WB) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("write-back did not pop one entry");

    // The divider only answers while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == rpnc_pkg::S_DIV))
        else $error("divider answer outside divide wait");

endmodule
